FILE: rtl/core/pidt_pkg.sv
package pidt_pkg;

  // Number of tanh segments over [0,1]; the table holds one more point than this.
  localparam int TANH_TABLE_DEPTH = 256;
  localparam int NBW = $clog2(TANH_TABLE_DEPTH + 1);

  // Shared multiplier: 33 x 33 signed, full product.
  localparam int MW = 33;
  localparam int PW = 2 * MW;
  // Sum of the three gain terms after dropping 16 fraction bits.
  localparam int RAW_W = PW - 16;
  // Integrator sum before clamping.
  localparam int INTW = 42;

  // Divider widths: the derivative needs 49 numerator bits, the table position
  // needs 31 + NBW + 16.
  localparam int DIVW = (47 + NBW > 49) ? 47 + NBW : 49;
  localparam int DSW = 32;
  localparam int CW = $clog2(DIVW + 1);

  localparam logic [63:0] Q28_ONE = 64'd1 << 28;

  typedef logic [NBW-1:0] tidx_t;
  typedef logic [TANH_TABLE_DEPTH:0][15:0] tanh_tbl_t;

  typedef enum logic [2:0] {
    CFG_KP_GAIN,
    CFG_KI_GAIN,
    CFG_KD_GAIN,
    CFG_ERROR_LIMIT,
    CFG_INTEGRAL_LIMIT,
    CFG_OUTPUT_LIMIT
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic [30:0]        el;
    logic [30:0]        il;
    logic [30:0]        ol;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ERR,
    S_MUL_EDT,
    S_INTEG,
    S_MUL_KP,
    S_MUL_KI,
    S_ACC_KI,
    S_DERIV,
    S_MUL_KD,
    S_ACC_KD,
    S_MAG,
    S_CHECK,
    S_MUL_N,
    S_DIV_POS,
    S_POS_WAIT,
    S_TBL,
    S_MUL_F,
    S_INTERP,
    S_OUT
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_MUL_EDT,
    OP_INTEG,
    OP_MUL_KP,
    OP_MUL_KI,
    OP_ACC,
    OP_DERIV,
    OP_MUL_KD,
    OP_MAG,
    OP_SAT,
    OP_MUL_N,
    OP_DIV_POS,
    OP_POS,
    OP_TBL,
    OP_MUL_F,
    OP_INTERP
  } dp_op_e;

  typedef struct packed {
    logic zero_dt;
    logic sat;
    logic div_done;
  } dp_status_t;

  // Restoring division used only while the table is built at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Builds the tanh points at elaboration from the exponential series of 2x.
  function automatic tanh_tbl_t tanh_table();
    tanh_tbl_t   t;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k <= TANH_TABLE_DEPTH; k++) begin
      y = udiv64(64'(k) << 29, 64'(TANH_TABLE_DEPTH));
      term = Q28_ONE;
      sum = Q28_ONE;
      for (int n = 1; n <= 30; n++) begin
        term = udiv64((term * y) >> 28, 64'(n));
        sum = sum + term;
      end
      t[k] = 16'(udiv64(((sum - Q28_ONE) * 64'd32768) + ((sum + Q28_ONE) >> 1),
                        sum + Q28_ONE));
    end
    return t;
  endfunction

  localparam tanh_tbl_t TANH_TBL = tanh_table();

endpackage

FILE: rtl/core/pidt_div.sv
module pidt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [pidt_pkg::DIVW-1:0]  num_i,
  input  logic [pidt_pkg::DSW-1:0]   den_i,
  output logic                       done_o,
  output logic [pidt_pkg::DIVW-1:0]  quo_o
);
  import pidt_pkg::*;

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [DSW-1:0]  rem_r;
  logic [DIVW-1:0] num_r;
  logic [DSW-1:0]  den_r;

  logic [DSW:0]    trial_w;
  logic [DSW:0]    sub_w;
  logic            ge_w;

  // One restoring step per cycle, quotient bits shift in behind the numerator.
  assign trial_w = {rem_r, num_r[DIVW-1]};
  assign sub_w   = trial_w - {1'b0, den_r};
  assign ge_w    = (trial_w >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(DIVW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= '0;
      num_r <= num_i;
      den_r <= den_i;
    end else if (busy_r) begin
      rem_r <= ge_w ? sub_w[DSW-1:0] : trial_w[DSW-1:0];
      num_r <= {num_r[DIVW-2:0], ge_w};
    end
  end

  assign done_o = done_r && !busy_r;
  assign quo_o  = num_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_r) else $error("divider restarted while busy");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start_i && cnt_r == CW'(1)) |=> (done_r && !busy_r))
    else $error("divider did not finish on its last step");
`endif

endmodule

FILE: rtl/core/pidt_ctrl.sv
module pidt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid_i,
  input  logic                   in_mode_i,
  input  logic                   out_free_i,
  input  pidt_pkg::dp_status_t   status_i,
  output logic                   in_stall_o,
  output logic                   out_load_o,
  output pidt_pkg::dp_op_e       op_o
);
  import pidt_pkg::*;

  ctrl_state_e state_r;
  ctrl_state_e state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid_i) begin
          state_nxt = in_mode_i ? S_OUT : S_ERR;
        end
      end
      S_ERR:     state_nxt = S_MUL_EDT;
      S_MUL_EDT: state_nxt = S_INTEG;
      S_INTEG:   state_nxt = S_MUL_KP;
      S_MUL_KP:  state_nxt = S_MUL_KI;
      S_MUL_KI:  state_nxt = S_ACC_KI;
      S_ACC_KI:  state_nxt = S_DERIV;
      S_DERIV: begin
        if (status_i.zero_dt || status_i.div_done) begin
          state_nxt = S_MUL_KD;
        end
      end
      S_MUL_KD:  state_nxt = S_ACC_KD;
      S_ACC_KD:  state_nxt = S_MAG;
      S_MAG:     state_nxt = S_CHECK;
      S_CHECK:   state_nxt = status_i.sat ? S_OUT : S_MUL_N;
      S_MUL_N:   state_nxt = S_DIV_POS;
      S_DIV_POS: state_nxt = S_POS_WAIT;
      S_POS_WAIT: begin
        if (status_i.div_done) begin
          state_nxt = S_TBL;
        end
      end
      S_TBL:     state_nxt = S_MUL_F;
      S_MUL_F:   state_nxt = S_INTERP;
      S_INTERP:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_free_i) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    out_load_o = 1'b0;
    op_o       = OP_NONE;
    case (state_r)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_o = OP_LOAD;
        end
      end
      S_ERR:     op_o = OP_ERR;
      S_MUL_EDT: op_o = OP_MUL_EDT;
      S_INTEG:   op_o = OP_INTEG;
      S_MUL_KP:  op_o = OP_MUL_KP;
      S_MUL_KI:  op_o = OP_MUL_KI;
      S_ACC_KI:  op_o = OP_ACC;
      S_DERIV: begin
        if (!status_i.zero_dt && status_i.div_done) begin
          op_o = OP_DERIV;
        end
      end
      S_MUL_KD:  op_o = OP_MUL_KD;
      S_ACC_KD:  op_o = OP_ACC;
      S_MAG:     op_o = OP_MAG;
      S_CHECK: begin
        if (status_i.sat) begin
          op_o = OP_SAT;
        end
      end
      S_MUL_N:   op_o = OP_MUL_N;
      S_DIV_POS: op_o = OP_DIV_POS;
      S_POS_WAIT: begin
        if (status_i.div_done) begin
          op_o = OP_POS;
        end
      end
      S_TBL:     op_o = OP_TBL;
      S_MUL_F:   op_o = OP_MUL_F;
      S_INTERP:  op_o = OP_INTERP;
      S_OUT:     out_load_o = out_free_i;
      default:   op_o = OP_NONE;
    endcase
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load_o |-> out_free_i) else $error("result loaded over a waiting one");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_i && !in_stall_o) |=> (state_r != S_IDLE))
    else $error("request accepted but controller stayed idle");
`endif

endmodule

FILE: rtl/core/pidt_dp.sv
module pidt_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pidt_pkg::dp_op_e     op_i,
  input  pidt_pkg::cfg_t       cfg_i,
  input  logic                 in_mode_i,
  input  logic signed [31:0]   in_setpoint_i,
  input  logic signed [31:0]   in_measured_i,
  input  logic [23:0]          in_step_time_i,
  output pidt_pkg::dp_status_t status_o,
  output logic signed [15:0]   res_drive_o,
  output logic                 res_sat_o,
  output logic                 res_zdt_o
);
  import pidt_pkg::*;

  localparam logic [DIVW-1:0] Q_LIM = DIVW'(64'h8000_0000);

  logic signed [31:0]       sp_r;
  logic signed [31:0]       ms_r;
  logic [23:0]              dt_r;
  logic signed [31:0]       err_r;
  logic signed [31:0]       last_r;
  logic signed [31:0]       integ_r;
  logic signed [31:0]       deriv_r;
  logic                     zdt_r;
  logic                     dneg_r;
  logic signed [RAW_W-1:0]  raw_r;
  logic                     neg_r;
  logic [RAW_W-1:0]         mag_r;
  logic [30:0]              lim_r;
  tidx_t                    k_r;
  logic [15:0]              f_r;
  logic [15:0]              a_r;
  logic [15:0]              b_r;
  logic signed [PW-1:0]     mul_p_r;
  logic signed [15:0]       res_drive_r;
  logic                     res_sat_r;
  logic                     res_zdt_r;

  logic signed [32:0]       diff_w;
  logic signed [32:0]       el_w;
  logic signed [32:0]       el_neg_w;
  logic signed [31:0]       err_w;
  logic signed [INTW-1:0]   integ_sum_w;
  logic signed [INTW-1:0]   il_w;
  logic signed [INTW-1:0]   il_neg_w;
  logic signed [31:0]       integ_w;
  logic signed [33:0]       dd_w;
  logic [33:0]              dmag_w;
  logic signed [RAW_W-1:0]  fl_w;
  logic [RAW_W-1:0]         raw_abs_w;
  logic signed [MW-1:0]     mul_a_w;
  logic signed [MW-1:0]     mul_b_w;
  logic                     div_start_w;
  logic [DIVW-1:0]          div_num_w;
  logic [DSW-1:0]           div_den_w;
  logic                     div_done_w;
  logic [DIVW-1:0]          quo_w;
  logic signed [31:0]       deriv_w;
  tidx_t                    k_w;
  tidx_t                    idx_a_w;
  tidx_t                    idx_b_w;
  logic [32:0]              frac_w;
  logic [15:0]              v_w;

  // Error clamp.
  assign diff_w   = {ms_r[31], ms_r} - {sp_r[31], sp_r};
  assign el_w     = signed'({2'b00, cfg_i.el});
  assign el_neg_w = -el_w;
  always_comb begin
    if (diff_w > el_w) begin
      err_w = el_w[31:0];
    end else if (diff_w < el_neg_w) begin
      err_w = el_neg_w[31:0];
    end else begin
      err_w = diff_w[31:0];
    end
  end

  // Integrator with anti-windup clamp; the product is floored by dropping bits.
  assign integ_sum_w = {{(INTW-32){integ_r[31]}}, integ_r} + mul_p_r[INTW+15:16];
  assign il_w        = signed'({{(INTW-31){1'b0}}, cfg_i.il});
  assign il_neg_w    = -il_w;
  always_comb begin
    if (integ_sum_w > il_w) begin
      integ_w = il_w[31:0];
    end else if (integ_sum_w < il_neg_w) begin
      integ_w = il_neg_w[31:0];
    end else begin
      integ_w = integ_sum_w[31:0];
    end
  end

  // Derivative numerator: the divider works on magnitudes, the sign is restored after.
  assign dd_w   = {{2{err_r[31]}}, err_r} - {{2{last_r[31]}}, last_r};
  assign dmag_w = dd_w[33] ? 34'(-dd_w) : 34'(dd_w);

  assign fl_w      = mul_p_r[PW-1:16];
  assign raw_abs_w = raw_r[RAW_W-1] ? RAW_W'(-raw_r) : RAW_W'(raw_r);

  always_comb begin
    mul_a_w = '0;
    mul_b_w = '0;
    case (op_i)
      OP_MUL_EDT: begin
        mul_a_w = {err_r[31], err_r};
        mul_b_w = {9'b0, dt_r};
      end
      OP_MUL_KP: begin
        mul_a_w = {cfg_i.kp[31], cfg_i.kp};
        mul_b_w = {err_r[31], err_r};
      end
      OP_MUL_KI: begin
        mul_a_w = {cfg_i.ki[31], cfg_i.ki};
        mul_b_w = {integ_r[31], integ_r};
      end
      OP_MUL_KD: begin
        mul_a_w = {cfg_i.kd[31], cfg_i.kd};
        mul_b_w = {deriv_r[31], deriv_r};
      end
      OP_MUL_N: begin
        mul_a_w = {2'b00, mag_r[30:0]};
        mul_b_w = MW'(TANH_TABLE_DEPTH);
      end
      OP_MUL_F: begin
        mul_a_w = {17'b0, 16'(b_r - a_r)};
        mul_b_w = {17'b0, f_r};
      end
      default: begin
        mul_a_w = '0;
        mul_b_w = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a_w * mul_b_w;
  end

  always_comb begin
    div_start_w = 1'b0;
    div_num_w   = '0;
    div_den_w   = '0;
    case (op_i)
      OP_INTEG: begin
        div_start_w = !zdt_r;
        div_num_w   = DIVW'({dmag_w[32:0], 16'b0});
        div_den_w   = {8'b0, dt_r};
      end
      OP_DIV_POS: begin
        div_start_w = 1'b1;
        div_num_w   = {mul_p_r[DIVW-17:0], 16'b0};
        div_den_w   = {1'b0, lim_r};
      end
      default: begin
        div_start_w = 1'b0;
      end
    endcase
  end

  pidt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start_w),
    .num_i   (div_num_w),
    .den_i   (div_den_w),
    .done_o  (div_done_w),
    .quo_o   (quo_w)
  );

  always_comb begin
    if (dneg_r) begin
      deriv_w = (quo_w > Q_LIM) ? 32'sh8000_0000 : signed'(-quo_w[31:0]);
    end else begin
      deriv_w = (quo_w >= Q_LIM) ? 32'sh7FFF_FFFF : signed'(quo_w[31:0]);
    end
  end

  // Table addresses; the end of the range reads the last point twice.
  assign k_w     = quo_w[NBW+15:16];
  assign idx_a_w = (k_r >= tidx_t'(TANH_TABLE_DEPTH)) ? tidx_t'(TANH_TABLE_DEPTH) : k_r;
  assign idx_b_w = (k_r >= tidx_t'(TANH_TABLE_DEPTH)) ? tidx_t'(TANH_TABLE_DEPTH)
                                                      : tidx_t'(k_r + 1'b1);
  assign frac_w  = {1'b0, mul_p_r[31:0]} + 33'd32768;
  assign v_w     = a_r + frac_w[31:16];

  // State kept between samples: cleared by reset and by the clear command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      last_r  <= '0;
    end else begin
      case (op_i)
        OP_LOAD: begin
          if (in_mode_i) begin
            integ_r <= '0;
            last_r  <= '0;
          end
        end
        OP_INTEG: begin
          integ_r <= integ_w;
          last_r  <= err_r;
        end
        default: begin
          integ_r <= integ_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op_i)
      OP_LOAD: begin
        sp_r        <= in_setpoint_i;
        ms_r        <= in_measured_i;
        dt_r        <= in_step_time_i;
        res_drive_r <= '0;
        res_sat_r   <= 1'b0;
        res_zdt_r   <= 1'b0;
      end
      OP_ERR: begin
        err_r <= err_w;
        zdt_r <= (dt_r == 24'd0);
      end
      OP_INTEG: begin
        dneg_r <= dd_w[33];
        if (zdt_r) begin
          deriv_r <= '0;
        end
      end
      OP_MUL_KI: raw_r <= fl_w;
      OP_ACC:    raw_r <= raw_r + fl_w;
      OP_DERIV:  deriv_r <= deriv_w;
      OP_MAG: begin
        mag_r <= raw_abs_w;
        neg_r <= raw_r[RAW_W-1];
        lim_r <= (cfg_i.ol == 31'd0) ? 31'd1 : cfg_i.ol;
      end
      OP_SAT: begin
        res_drive_r <= neg_r ? 16'sh8000 : 16'sh7FFF;
        res_sat_r   <= 1'b1;
        res_zdt_r   <= zdt_r;
      end
      OP_POS: begin
        k_r <= k_w;
        f_r <= quo_w[15:0];
      end
      OP_TBL: begin
        a_r <= TANH_TBL[idx_a_w];
        b_r <= TANH_TBL[idx_b_w];
      end
      OP_INTERP: begin
        res_drive_r <= neg_r ? signed'(-v_w) : signed'(v_w);
        res_sat_r   <= 1'b0;
        res_zdt_r   <= zdt_r;
      end
      default: begin
        sp_r <= sp_r;
      end
    endcase
  end

  assign status_o.zero_dt  = zdt_r;
  assign status_o.sat      = (mag_r > RAW_W'(lim_r));
  assign status_o.div_done = div_done_w;

  assign res_drive_o = res_drive_r;
  assign res_sat_o   = res_sat_r;
  assign res_zdt_o   = res_zdt_r;

endmodule

FILE: rtl/core/pid_with_clamps_and_tanh_output.sv
// PID controller with a clamped error, an anti-windup clamp on the integral and a
// tanh-shaped output. Each request is either a clear command, which zeroes the
// integral and the stored previous error and presents a zero result, or a sample.
// A sample is worked through one step at a time by a controller and a datapath
// that share one 33 x 33 signed multiplier and one restoring divider that retires
// one quotient bit per cycle over DIVW (56) bits. The divider sets the pace: it
// runs once for the derivative and, unless the output saturates, once for the
// position in the tanh table. A zero step time skips the derivative division.
// Only one request is in flight at a time; the finished result sits in an output
// register, so the next request may be accepted while the previous result is
// still stalled, and that request then waits for the slot before finishing.
// Configuration registers are written through the cfg port; the user must write
// them only with the block idle, as the block itself does not enforce this.
module pid_with_clamps_and_tanh_output (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [31:0] in_setpoint,
  input  logic signed [31:0] in_measured,
  input  logic [23:0]        in_step_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_drive,
  output logic               out_output_saturated,
  output logic               out_zero_time_step,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import pidt_pkg::*;

  cfg_t               cfg_r;
  logic               out_valid_r;
  logic signed [15:0] out_drive_r;
  logic               out_sat_r;
  logic               out_zdt_r;

  dp_op_e             op_w;
  dp_status_t         status_w;
  logic               out_free_w;
  logic               out_load_w;
  logic signed [15:0] res_drive_w;
  logic               res_sat_w;
  logic               res_zdt_w;

  // Register file: indexes six and seven are not decoded and are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp <= 32'sh0044_0000;
      cfg_r.ki <= 32'sh001C_0000;
      cfg_r.kd <= 32'sh0000_0000;
      cfg_r.el <= 31'h01F4_0000;
      cfg_r.il <= 31'h0005_0000;
      cfg_r.ol <= 31'h03E8_0000;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index))
        CFG_KP_GAIN:        cfg_r.kp <= cfg_wdata;
        CFG_KI_GAIN:        cfg_r.ki <= cfg_wdata;
        CFG_KD_GAIN:        cfg_r.kd <= cfg_wdata;
        CFG_ERROR_LIMIT:    cfg_r.el <= cfg_wdata[30:0];
        CFG_INTEGRAL_LIMIT: cfg_r.il <= cfg_wdata[30:0];
        CFG_OUTPUT_LIMIT:   cfg_r.ol <= cfg_wdata[30:0];
        default:            cfg_r    <= cfg_r;
      endcase
    end
  end

  // The output slot is free when empty or when its result leaves this cycle.
  assign out_free_w = !out_valid_r || !out_stall;

  pidt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_valid),
    .in_mode_i  (in_mode),
    .out_free_i (out_free_w),
    .status_i   (status_w),
    .in_stall_o (in_stall),
    .out_load_o (out_load_w),
    .op_o       (op_w)
  );

  pidt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op_i           (op_w),
    .cfg_i          (cfg_r),
    .in_mode_i      (in_mode),
    .in_setpoint_i  (in_setpoint),
    .in_measured_i  (in_measured),
    .in_step_time_i (in_step_time),
    .status_o       (status_w),
    .res_drive_o    (res_drive_w),
    .res_sat_o      (res_sat_w),
    .res_zdt_o      (res_zdt_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_w) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_w) begin
      out_drive_r <= res_drive_w;
      out_sat_r   <= res_sat_w;
      out_zdt_r   <= res_zdt_w;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drive            = out_drive_r;
  assign out_output_saturated = out_sat_r;
  assign out_zero_time_step   = out_zdt_r;

endmodule
